// ----- rtl/bsrw_pkg.sv -----
`default_nettype none
package bsrw_pkg;

  localparam int BYTE_BITS = 8;
  localparam int DATA_W    = 64;
  localparam int START_W   = 11;
  localparam int LEN_W     = 7;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/bsrw_byte_ram.sv -----
`default_nettype none
module bsrw_byte_ram #(
  parameter int STORE_BYTES = 256,
  parameter int AW          = $clog2(STORE_BYTES)
) (
  input  wire logic                            clk,
  input  wire logic                            re,
  input  wire logic [AW-1:0]                   raddr,
  output logic [bsrw_pkg::BYTE_BITS-1:0]       rdata,
  input  wire logic                            we,
  input  wire logic [AW-1:0]                   waddr,
  input  wire logic [bsrw_pkg::BYTE_BITS-1:0]  wdata
);

  logic [bsrw_pkg::BYTE_BITS-1:0] mem [STORE_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bsrw_serial_unit.sv -----
`default_nettype none
module bsrw_serial_unit #(
  parameter int MAX_SLICE_BITS = 64,
  parameter int AW             = 8,
  parameter int NB             = (MAX_SLICE_BITS + 14) / 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire bsrw_pkg::ctrl_t                   ctrl,
  input  wire logic                              is_write,
  input  wire logic [bsrw_pkg::START_W-1:0]      start,
  input  wire logic [bsrw_pkg::LEN_W-1:0]        len,
  input  wire logic [bsrw_pkg::DATA_W-1:0]       data,
  output logic                                   re,
  output logic [AW-1:0]                          raddr,
  input  wire logic [bsrw_pkg::BYTE_BITS-1:0]    rdata,
  output logic                                   we,
  output logic [AW-1:0]                          waddr,
  output logic [bsrw_pkg::BYTE_BITS-1:0]         wdata,
  output logic [MAX_SLICE_BITS-1:0]              slice
);

  localparam int BB = bsrw_pkg::BYTE_BITS;
  localparam int SW = NB * BB;

  logic [SW-1:0]             mask_sr;
  logic [SW-1:0]             data_sr;
  logic [SW-1:0]             acc;
  logic [AW-1:0]             ptr;
  logic [2:0]                off;
  logic                      wr;
  logic                      p_valid;
  logic [BB-1:0]             p_mask;
  logic [BB-1:0]             p_data;
  logic [AW-1:0]             p_addr;
  logic [MAX_SLICE_BITS-1:0] therm;
  logic [SW-1:0]             shifted;

  always_comb begin
    for (int i = 0; i < MAX_SLICE_BITS; i++) begin
      therm[i] = (bsrw_pkg::LEN_W'(i) < len);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mask_sr <= SW'(therm) << start[2:0];
      data_sr <= SW'(data[MAX_SLICE_BITS-1:0]) << start[2:0];
      ptr     <= AW'(start[bsrw_pkg::START_W-1:3]);
      off     <= start[2:0];
      wr      <= is_write;
    end else if (ctrl.step) begin
      mask_sr <= mask_sr >> BB;
      data_sr <= data_sr >> BB;
      ptr     <= ptr + AW'(1);
    end
    if (ctrl.step) begin
      p_mask <= mask_sr[BB-1:0];
      p_data <= data_sr[BB-1:0];
      p_addr <= ptr;
    end
    if (p_valid) begin
      acc <= {rdata & p_mask, acc[SW-1:BB]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= ctrl.step;
    end
  end

  assign re    = ctrl.step & (|mask_sr[BB-1:0]);
  assign raddr = ptr;
  assign we    = p_valid & wr & (|p_mask);
  assign waddr = p_addr;
  assign wdata = (rdata & ~p_mask) | (p_data & p_mask);

  assign shifted = acc >> off;
  assign slice   = shifted[MAX_SLICE_BITS-1:0];

endmodule
`default_nettype wire

// ----- rtl/bit_slice_read_write.sv -----
`default_nettype none
// Bit-addressable byte store. Each request reads or writes a slice of
// 1 to MAX_SLICE_BITS bits starting at any bit position; store bits are
// LSB-first within each byte. Reads return the slice right-aligned with
// zeros above the length; writes merge the low bit_len bits of write_data
// and return zero. A slice past the store end, or a bad length, sets
// range_error and leaves the store untouched. The slice is moved one byte
// per cycle as a read-modify-write through the byte RAM's read and write
// ports; a rejected request skips the byte moves and goes straight to
// the result. A new request is taken once the previous one has moved to
// the output register.
// Store contents are undefined until written.
module bit_slice_read_write #(
  parameter int STORE_BYTES    = 256,
  parameter int MAX_SLICE_BITS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           req_type,
  input  wire logic [bsrw_pkg::START_W-1:0]   bit_start,
  input  wire logic [bsrw_pkg::LEN_W-1:0]     bit_len,
  input  wire logic [bsrw_pkg::DATA_W-1:0]    write_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [bsrw_pkg::DATA_W-1:0]         read_data,
  output logic                                range_error
);

  localparam int AW         = $clog2(STORE_BYTES);
  localparam int NB         = (MAX_SLICE_BITS + 14) / 8;
  localparam int CW         = $clog2(NB + 1);
  localparam int TOTAL_BITS = STORE_BYTES * bsrw_pkg::BYTE_BITS;

  bsrw_pkg::state_t state;
  bsrw_pkg::ctrl_t  ctrl;
  logic [CW-1:0]    cnt;
  logic             err;
  logic             wr;
  logic             accept;
  logic             bad;
  logic             out_load;
  logic             re;
  logic             we;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [bsrw_pkg::BYTE_BITS-1:0] rdata;
  logic [bsrw_pkg::BYTE_BITS-1:0] wdata;
  logic [MAX_SLICE_BITS-1:0]      slice;

  assign in_ready = (state == bsrw_pkg::ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign bad      = (bit_len == '0)
                 || (32'(bit_len) > 32'(MAX_SLICE_BITS))
                 || ((32'(bit_start) + 32'(bit_len)) > 32'(TOTAL_BITS));
  assign out_load = (state == bsrw_pkg::ST_FINISH) & (~out_valid | out_ready);

  assign ctrl.load = accept & ~bad;
  assign ctrl.step = (state == bsrw_pkg::ST_RUN) & (cnt < CW'(NB));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bsrw_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        bsrw_pkg::ST_IDLE: begin
          if (accept) begin
            cnt   <= '0;
            state <= bad ? bsrw_pkg::ST_FINISH : bsrw_pkg::ST_RUN;
          end
        end
        bsrw_pkg::ST_RUN: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(NB)) begin
            state <= bsrw_pkg::ST_FINISH;
          end
        end
        bsrw_pkg::ST_FINISH: begin
          if (out_load) begin
            state <= bsrw_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= bsrw_pkg::ST_IDLE;
        end
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err <= bad;
      wr  <= (req_type == bsrw_pkg::REQ_WRITE);
    end
    if (out_load) begin
      range_error <= err;
      read_data   <= (err | wr) ? '0 : bsrw_pkg::DATA_W'(slice);
    end
  end

  bsrw_serial_unit #(
    .MAX_SLICE_BITS (MAX_SLICE_BITS),
    .AW             (AW),
    .NB             (NB)
  ) u_serial (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .is_write (req_type == bsrw_pkg::REQ_WRITE),
    .start    (bit_start),
    .len      (bit_len),
    .data     (write_data),
    .re       (re),
    .raddr    (raddr),
    .rdata    (rdata),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .slice    (slice)
  );

  bsrw_byte_ram #(
    .STORE_BYTES (STORE_BYTES),
    .AW          (AW)
  ) u_ram (
    .clk   (clk),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata)
  );

endmodule
`default_nettype wire

// ----- sim/tb_bit_slice_read_write.sv -----
`timescale 1ns / 100ps
module tb_bit_slice_read_write;

  localparam int STORE_BYTES    = 256;
  localparam int MAX_SLICE_BITS = 64;
  localparam int STORE_BITS     = STORE_BYTES * bsrw_pkg::BYTE_BITS;
  localparam int STALL_LIMIT    = 4000;
  localparam int RANDOM_ITEMS   = 1950;
  localparam int BLOCK_ITEMS    = 150;
  localparam int PRINT_CAP      = 100;

  typedef logic [bsrw_pkg::DATA_W-1:0] word_t;

  typedef struct {
    word_t data;
    logic  err;
  } reply_t;

  class slice_board;
    bit [bsrw_pkg::BYTE_BITS-1:0] mem [STORE_BYTES];
    bit                           written [STORE_BITS];
    reply_t                       awaited [$];
    int                           mismatches;
    int                           reads;
    int                           writes;
    int                           rejects;

    function bit rejected(int start, int len);
      return len == 0 || len > MAX_SLICE_BITS || start + len > STORE_BITS;
    endfunction

    function bit readable(int start, int len);
      for (int i = 0; i < len; i++) begin
        if (!written[start + i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_request(logic kind, logic [bsrw_pkg::START_W-1:0] start_f,
                               logic [bsrw_pkg::LEN_W-1:0] len_f, word_t data);
      reply_t r;
      int     start;
      int     len;
      int     p;
      start  = int'(start_f);
      len    = int'(len_f);
      r.data = '0;
      r.err  = 1'b0;
      if (rejected(start, len)) begin
        r.err = 1'b1;
        rejects++;
      end else if (kind == bsrw_pkg::REQ_WRITE) begin
        for (int i = 0; i < len; i++) begin
          p = start + i;
          mem[p / bsrw_pkg::BYTE_BITS][p % bsrw_pkg::BYTE_BITS] = data[i];
          written[p] = 1'b1;
        end
        writes++;
      end else begin
        for (int i = 0; i < len; i++) begin
          p = start + i;
          r.data[i] = mem[p / bsrw_pkg::BYTE_BITS][p % bsrw_pkg::BYTE_BITS];
        end
        reads++;
      end
      awaited.push_back(r);
    endfunction

    task flag_mismatch(string what);
      if (mismatches < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(word_t data, logic err);
      reply_t r;
      if (awaited.size() == 0) begin
        flag_mismatch($sformatf("unrequested result, read_data %h range_error %b",
                                data, err));
        return;
      end
      r = awaited.pop_front();
      if (data !== r.data)
        flag_mismatch($sformatf("read_data %h, want %h", data, r.data));
      if (err !== r.err)
        flag_mismatch($sformatf("range_error %b, want %b", err, r.err));
    endtask
  endclass

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic                          req_type;
  logic [bsrw_pkg::START_W-1:0]  bit_start;
  logic [bsrw_pkg::LEN_W-1:0]    bit_len;
  logic [bsrw_pkg::DATA_W-1:0]   write_data;
  logic                          out_valid;
  logic                          out_ready;
  logic [bsrw_pkg::DATA_W-1:0]   read_data;
  logic                          range_error;

  slice_board board = new;
  bit         calm;
  int         idle_cycles = 0;

  bit_slice_read_write #(
    .STORE_BYTES    (STORE_BYTES),
    .MAX_SLICE_BITS (MAX_SLICE_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .bit_start   (bit_start),
    .bit_len     (bit_len),
    .write_data  (write_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_data   (read_data),
    .range_error (range_error)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_slice(logic kind, int start, int len, word_t data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    bit_start  <= start[bsrw_pkg::START_W-1:0];
    bit_len    <= len[bsrw_pkg::LEN_W-1:0];
    write_data <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(kind, start[bsrw_pkg::START_W-1:0], len[bsrw_pkg::LEN_W-1:0], data);
    @(negedge clk);
  endtask

  task automatic send_random_slice();
    int    r;
    int    start;
    int    len;
    logic  kind;
    word_t data;
    r    = $urandom_range(0, 99);
    kind = logic'($urandom_range(0, 1));
    data = {$urandom, $urandom};
    if (r < 6) begin
      len   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_SLICE_BITS + 1, 127);
      start = $urandom_range(0, STORE_BITS - 1);
    end else if (r < 12) begin
      len   = $urandom_range(2, MAX_SLICE_BITS);
      start = $urandom_range(STORE_BITS - len + 1, STORE_BITS - 1);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 20) len = MAX_SLICE_BITS;
      else if (r < 30) len = 1;
      else len = $urandom_range(1, MAX_SLICE_BITS);
      start = $urandom_range(0, STORE_BITS - len);
      if (kind == bsrw_pkg::REQ_READ && !board.readable(start, len)) begin
        kind = bsrw_pkg::REQ_WRITE;
      end
    end
    send_slice(kind, start, len, data);
  endtask

  initial begin
    int stall;
    int run;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      run = $urandom_range(1, 12);
      repeat (run) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(read_data, range_error);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
        $display("tb_bit_slice_read_write failed");
        $finish;
      end
    end
  end

  initial begin
    int n;
    rst         = 1'b1;
    in_valid    = 1'b0;
    req_type    = bsrw_pkg::REQ_READ;
    bit_start   = '0;
    bit_len     = '0;
    write_data  = '0;
    calm        = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_slice(bsrw_pkg::REQ_WRITE, 0, 64, '1);
    send_slice(bsrw_pkg::REQ_READ, 0, 64, '0);
    send_slice(bsrw_pkg::REQ_WRITE, 0, 1, '0);
    send_slice(bsrw_pkg::REQ_READ, 0, 1, '1);
    send_slice(bsrw_pkg::REQ_WRITE, STORE_BITS - 64, 64, 64'h0123_4567_89ab_cdef);
    send_slice(bsrw_pkg::REQ_READ, STORE_BITS - 64, 64, '0);
    send_slice(bsrw_pkg::REQ_WRITE, STORE_BITS - 1, 1, 64'h1);
    send_slice(bsrw_pkg::REQ_READ, STORE_BITS - 1, 1, '0);
    send_slice(bsrw_pkg::REQ_WRITE, STORE_BITS - 1, 2, '1);
    send_slice(bsrw_pkg::REQ_READ, 2000, 49, '0);
    send_slice(bsrw_pkg::REQ_READ, 5, 0, '0);
    send_slice(bsrw_pkg::REQ_WRITE, 5, MAX_SLICE_BITS + 1, '1);
    send_slice(bsrw_pkg::REQ_READ, 0, 127, '0);
    send_slice(bsrw_pkg::REQ_WRITE, STORE_BITS - 1, 127, '1);
    send_slice(bsrw_pkg::REQ_READ, STORE_BITS - 1, 127, '1);
    send_slice(bsrw_pkg::REQ_WRITE, 3, 13, 64'haaaa);
    send_slice(bsrw_pkg::REQ_READ, 0, 20, '0);
    send_slice(bsrw_pkg::REQ_WRITE, 60, 64, 64'hdead_beef_5a5a_c3c3);
    send_slice(bsrw_pkg::REQ_READ, 56, 64, '0);
    send_slice(bsrw_pkg::REQ_READ, 60, 64, '0);
    send_slice(bsrw_pkg::REQ_WRITE, 1990, 7, 64'hffff_ffff_ffff_ff80);
    send_slice(bsrw_pkg::REQ_READ, STORE_BITS - 64, 64, '0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm = ((n / BLOCK_ITEMS) % 4) == 2;
      send_random_slice();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (board.awaited.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d reads, %0d writes and %0d rejected slices", board.reads,
             board.writes, board.rejects);
    $display("%0d mismatches, %0d results still pending", board.mismatches,
             board.awaited.size());
    if (board.mismatches == 0 && board.awaited.size() == 0) begin
      $display("tb_bit_slice_read_write passed");
    end else begin
      $display("tb_bit_slice_read_write failed");
    end
    $finish;
  end

endmodule
